FILE: hw/rtl/sfr_pkg.sv
package sfr_pkg;

    // default buffer depth in bytes
    localparam int unsigned BUFFER_DEPTH_DEF = 256;

    // field widths fixed by the item format
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned LENGTH_W = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // special characters
    localparam logic [BYTE_W-1:0] CH_STX   = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
    localparam logic [BYTE_W-1:0] ADDR_ANY = 8'h7F;
    localparam logic [BYTE_W-1:0] MASK7    = 8'h7F;
    localparam logic [BYTE_W-1:0] ADDR_BCAST = 8'h00;

    // receiver state
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RECV = 2'd1,
        ST_DONE = 2'd2
    } rx_state_t;

    // item action codes
    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_READ    = 2'd2,
        ACT_RELEASE = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_MODE    = 3'd0,
        REG_DEVICE_NUMBER = 3'd1,
        REG_ADDRESS_BASE  = 3'd2,
        REG_SEVEN_BIT     = 3'd3,
        REG_GAP_TICKS     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                frame_mode;
        logic [BYTE_W-1:0]   device_number;
        logic [BYTE_W-1:0]   address_base;
        logic                seven_bit;
        logic [TIMER_W-1:0]  gap_ticks;
    } cfg_t;

    // per-item result handed from control to the output pipeline
    typedef struct packed {
        logic [1:0]          frame_state;
        logic [LENGTH_W-1:0] frame_length;
        logic                rd_ok;
    } result_t;

endpackage

FILE: hw/rtl/sfr_buffer.sv
module sfr_buffer #(
    parameter int unsigned DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [sfr_pkg::BYTE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [sfr_pkg::BYTE_W-1:0] rd_data
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sfr_ctrl.sv
module sfr_ctrl #(
    parameter int unsigned DEPTH = sfr_pkg::BUFFER_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned WPW   = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       item_en,
    input  logic [1:0]                 action,
    input  logic [sfr_pkg::BYTE_W-1:0] data_byte,
    input  logic                       transmitting,
    input  logic [sfr_pkg::BYTE_W-1:0] read_index,
    input  sfr_pkg::cfg_t              cfg,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [sfr_pkg::BYTE_W-1:0] wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    output sfr_pkg::result_t           res
);
    import sfr_pkg::*;

    rx_state_t           state_reg, state_next;
    logic [WPW-1:0]      wp_reg, wp_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [BYTE_W-1:0]   byte0_reg, byte0_next;
    logic [BYTE_W-1:0]   byte1_reg, byte1_next;

    logic [BYTE_W-1:0]   b;
    logic                tx;
    logic [TIMER_W-1:0]  gap_load;
    logic [TIMER_W-1:0]  timer_dec;
    logic                room;
    logic                wr_start;
    logic                wr_append;
    logic [BYTE_W-1:0]   got1;
    logic [BYTE_W:0]     want;
    logic [AW+BYTE_W-1:0] idx_ext;
    logic [WPW+LENGTH_W-1:0] len_ext;
    logic [WPW+AW-1:0]   wp_ext;

    assign gap_load  = (cfg.gap_ticks == '0) ? TIMER_W'(1) : cfg.gap_ticks;
    assign timer_dec = timer_reg - TIMER_W'(1);
    assign room      = (wp_reg < WPW'(DEPTH));
    assign want      = {1'b0, cfg.address_base} + {1'b0, cfg.device_number};
    assign wp_ext    = {{AW{1'b0}}, wp_reg};

    // byte masking and echo suppression
    always_comb begin
        b  = data_byte;
        tx = transmitting;
        if (cfg.frame_mode) begin
            if (cfg.seven_bit) begin
                b = data_byte & MASK7;
            end
            if (b == CH_ETX) begin
                tx = 1'b0;
            end
        end
    end

    // index 1 as it stands after this item's write
    assign got1 = (wp_reg == WPW'(1)) ? b : byte1_reg;

    // next state for one item
    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        timer_next = timer_reg;
        wr_start   = 1'b0;
        wr_append  = 1'b0;
        case (action_t'(action))
            ACT_BYTE: begin
                if (!tx) begin
                    if (!cfg.frame_mode) begin
                        if (state_reg == ST_IDLE) begin
                            wr_start   = 1'b1;
                            wp_next    = WPW'(1);
                            state_next = ST_RECV;
                            timer_next = gap_load;
                        end else if (state_reg == ST_RECV && room) begin
                            wr_append  = 1'b1;
                            wp_next    = wp_reg + WPW'(1);
                            timer_next = gap_load;
                        end else if (state_reg != ST_DONE) begin
                            state_next = ST_IDLE;
                            timer_next = '0;
                        end
                    end else begin
                        if (b == CH_STX) begin
                            wr_start   = 1'b1;
                            wp_next    = WPW'(1);
                            state_next = ST_RECV;
                        end else if (state_reg == ST_RECV && room) begin
                            wr_append = 1'b1;
                            wp_next   = wp_reg + WPW'(1);
                            if (b == CH_ETX) begin
                                state_next = ({1'b0, got1} == want || got1 == ADDR_ANY)
                                             ? ST_DONE : ST_IDLE;
                            end
                        end else if (state_reg != ST_DONE) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ACT_TICK: begin
                if (!cfg.frame_mode && state_reg == ST_RECV && timer_reg != '0) begin
                    timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        state_next = (byte0_reg == cfg.device_number ||
                                      byte0_reg == ADDR_BCAST) ? ST_DONE : ST_IDLE;
                    end
                end
            end
            ACT_READ: begin
            end
            ACT_RELEASE: begin
                state_next = ST_IDLE;
                timer_next = '0;
            end
            default: begin
            end
        endcase
    end

    // buffer write request and address shadows
    assign wr_en   = item_en && (wr_start || wr_append);
    assign wr_addr = wr_start ? '0 : wp_ext[AW-1:0];
    assign wr_data = b;

    always_comb begin
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        if (wr_en && wr_addr == AW'(0)) begin
            byte0_next = b;
        end
        if (wr_en && wr_addr == AW'(1)) begin
            byte1_next = b;
        end
    end

    // buffer read request
    assign idx_ext = {{AW{1'b0}}, read_index};
    assign rd_addr = idx_ext[AW-1:0];
    assign rd_en   = item_en && (action_t'(action) == ACT_READ);

    // result after this item
    assign len_ext          = {{LENGTH_W{1'b0}}, wp_next};
    assign res.frame_state  = state_next;
    assign res.frame_length = len_ext[LENGTH_W-1:0];
    assign res.rd_ok        = (action_t'(action) == ACT_READ) && (idx_ext < (AW+BYTE_W)'(DEPTH));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            timer_reg <= '0;
        end else if (item_en) begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            timer_reg <= timer_next;
        end
    end

    // copies of buffer entries zero and one for the address filters
    always_ff @(posedge aclk) begin
        if (item_en) begin
            byte0_reg <= byte0_next;
            byte1_reg <= byte1_next;
        end
    end

endmodule

FILE: hw/rtl/sfr_cfg_regs.sv
module sfr_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output sfr_pkg::cfg_t                  cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    // register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_MODE:    cfg_next.frame_mode    = cfg_data[0];
                REG_DEVICE_NUMBER: cfg_next.device_number = cfg_data[BYTE_W-1:0];
                REG_ADDRESS_BASE:  cfg_next.address_base  = cfg_data[BYTE_W-1:0];
                REG_SEVEN_BIT:     cfg_next.seven_bit     = cfg_data[0];
                REG_GAP_TICKS:     cfg_next.gap_ticks     = cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_mode    <= 1'b0;
            cfg_reg.device_number <= BYTE_W'(1);
            cfg_reg.address_base  <= BYTE_W'(32);
            cfg_reg.seven_bit     <= 1'b0;
            cfg_reg.gap_ticks     <= TIMER_W'(4);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/serial_frame_receiver_top.sv
// a result item is held in the first result stage and then in the output register after its input item is accepted
// throughput: one item per cycle while m_axis_tready stays high; the buffer memory has one write and one read port
// and the single registered read sits in the first result stage
// reset: aresetn (synchronous, active low) returns to idle with length and timer zero
// and restores register defaults; buffer contents stay undefined, no clearing pass
module serial_frame_receiver_top #(
    parameter int unsigned BUFFER_DEPTH = sfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata, // data_byte, transmitting, read_index
    input  logic [1:0]                     s_axis_tuser, // action
    // result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata  // frame_state, frame_length, read_data
);
    import sfr_pkg::*;

    localparam int unsigned AW  = $clog2(BUFFER_DEPTH);
    localparam int unsigned WPW = $clog2(BUFFER_DEPTH + 1);

    cfg_t              cfg;
    logic              s_accept;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    result_t           res;

    // first result stage, waits on the memory read
    logic              a_valid_reg;
    result_t           a_res_reg;
    // output register
    logic              o_valid_reg;
    logic [1:0]        o_state_reg;
    logic [LENGTH_W-1:0] o_length_reg;
    logic [BYTE_W-1:0] o_data_reg;
    logic              a_advance;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_ctrl #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW),
        .WPW   (WPW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_en      (s_accept),
        .action       (s_axis_tuser),
        .data_byte    (s_axis_tdata[7:0]),
        .transmitting (s_axis_tdata[8]),
        .read_index   (s_axis_tdata[16:9]),
        .cfg          (cfg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .res          (res)
    );

    sfr_buffer #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake through the two result stages
    assign a_advance     = a_valid_reg && (!o_valid_reg || m_axis_tready);
    assign s_axis_tready = !a_valid_reg || a_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_advance) begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance) begin
                o_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_res_reg <= res;
        end
        if (a_advance) begin
            o_state_reg  <= a_res_reg.frame_state;
            o_length_reg <= a_res_reg.frame_length;
            o_data_reg   <= a_res_reg.rd_ok ? rd_data : '0;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {5'b0, o_data_reg, o_length_reg, o_state_reg};

endmodule
